### src/assert_macros.svh
// Assertion macros shared by the lru page replacement RTL.
// Every check is clocked on the rising edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define LRUPR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// If ante holds at one edge, cons must hold at the next edge.
`define LRUPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### src/lrupr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Types and constants shared by the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int unsigned CfgW   = 4;
  localparam int unsigned CountW = 32;

  localparam logic [CfgW-1:0]   FramesReset = 4'd3;
  localparam logic [CountW-1:0] CountMax    = '1;

  // Command broadcast to every cell of the recency row
  typedef struct packed {
    logic en;    // word accepted this cycle
    logic hit;   // page is resident
    logic fill;  // a free frame is still available
  } lrupr_op_t;

endpackage

### src/lrupr_page_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_page_if
// Request channel: one page reference per word.
// ----------------------------------------------------------------------------
interface lrupr_page_if #(
  parameter int unsigned PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

### src/lrupr_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_res_if
// Result channel: hit or fault, evicted page and running fault count.
// ----------------------------------------------------------------------------
interface lrupr_res_if #(
  parameter int unsigned PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 fault;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [31:0]          fault_count;

  modport source (output valid, output fault, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input fault, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

### src/lrupr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_cell
// One frame of the recency row: holds a page and its valid bit.
// ----------------------------------------------------------------------------
module lrupr_cell #(
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrupr_pkg::lrupr_op_t op_i,
  input  logic [PAGE_BITS-1:0] ref_page_i,     // page being looked up
  input  logic [PAGE_BITS-1:0] prev_page_i,    // page of the more recent neighbour
  input  logic                 prev_valid_i,
  input  logic                 next_valid_i,   // valid bit of the less recent neighbour
  input  logic                 hit_below_i,    // match in a less recent frame
  input  logic [PAGE_BITS-1:0] tail_below_i,   // oldest page beyond this frame
  output logic                 valid_o,
  output logic [PAGE_BITS-1:0] page_o,
  output logic                 hit_o,          // match in this frame
  output logic                 hit_below_o,    // match here or further down
  output logic [PAGE_BITS-1:0] tail_o          // oldest resident page from here down
);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic                 shift;

  assign hit_o       = valid_q && (page_q == ref_page_i);
  assign hit_below_o = hit_o || hit_below_i;
  assign tail_o      = next_valid_i ? tail_below_i : page_q;

  // On a hit shift down to the matching frame, on a fill down to the first
  // free frame, on an eviction down to the last resident frame.
  always_comb begin
    priority if (op_i.hit) begin
      shift = hit_below_o;
    end else if (op_i.fill) begin
      shift = prev_valid_i;
    end else begin
      shift = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (op_i.en && shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en && shift) begin
      page_q <= prev_page_i;
    end
  end

  assign valid_o = valid_q;
  assign page_o  = page_q;

endmodule

### src/lrupr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_out_buf
// Output register with one skid entry, decoupling the row from the sink.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrupr_out_buf #(
  parameter int unsigned W = 50
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic         out_valid_q;
  logic [W-1:0] out_data_q;
  logic         skid_valid_q;
  logic [W-1:0] skid_data_q;
  logic         in_fire;
  logic         out_free;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // drain the skid entry first, else take the new word
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_fire) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `LRUPR_ASSERT(a_skid_behind_out, clk_i, rst_ni, !skid_valid_q || out_valid_q, "skid holds a word while output register empty")
  `LRUPR_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q && (out_data_q == $past(out_data_q)), "stalled output word changed")

endmodule

### src/lru_page_replacement.sv
`timescale 1ns / 1ps
// A result word is formed by a combinational row compare and registered before res_o.
// Throughput: one page word per cycle while page_i.ready is high (skid entry empty).
// The output register with its skid entry keeps page_i ready while one result waits.
// Reset: every frame empty, fault count zero, frame limit 3; no clearing pass.
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement unit built as a row of frame cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrupr_pkg::CfgW-1:0]    cfg_wdata_i,
  lrupr_page_if.sink                    page_i,
  lrupr_res_if.source                   res_o
);

  localparam int unsigned IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CntW = lrupr_pkg::CountW;
  localparam int unsigned ResW = 2 + PAGE_BITS + CntW;

  // --------------------------------------------------------------------------
  // Configuration: frame limit register
  // --------------------------------------------------------------------------
  logic [lrupr_pkg::CfgW-1:0] frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lrupr_pkg::FramesReset;
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  // Clamp the limit into 1..MAX_FRAMES and form the index of the last frame
  // that may be used; a free frame remains while that frame is empty.
  logic [31:0]     lim;
  logic [31:0]     lim_m1;
  logic [IdxW-1:0] lim_idx;

  always_comb begin
    priority if (frames_q == '0) begin
      lim = 32'd1;
    end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
      lim = 32'(MAX_FRAMES);
    end else begin
      lim = 32'(frames_q);
    end
    lim_m1  = lim - 32'd1;
    lim_idx = lim_m1[IdxW-1:0];
  end

  // --------------------------------------------------------------------------
  // Frame row: cell 0 holds the most recent page
  // --------------------------------------------------------------------------
  logic                 accept;
  logic                 buf_ready;
  lrupr_pkg::lrupr_op_t op;
  logic                 hit;
  logic                 fill;

  logic [MAX_FRAMES-1:0] cell_valid;
  logic [MAX_FRAMES-1:0] cell_hit;
  logic [MAX_FRAMES-1:0] cell_hit_below;
  logic [PAGE_BITS-1:0]  cell_page [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  cell_tail [MAX_FRAMES];

  assign accept       = page_i.valid && buf_ready;
  assign page_i.ready = buf_ready;

  assign hit  = cell_hit_below[0];
  assign fill = !cell_valid[lim_idx];

  assign op.en   = accept;
  assign op.hit  = hit;
  assign op.fill = fill;

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    logic [PAGE_BITS-1:0] prev_page;
    logic                 prev_valid;
    logic                 next_valid;
    logic                 hit_below;
    logic [PAGE_BITS-1:0] tail_below;

    // the head cell takes the referenced page itself
    if (k == 0) begin : g_head
      assign prev_page  = page_i.page_number;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_page  = cell_page[k-1];
      assign prev_valid = cell_valid[k-1];
    end

    // the tail cell sees an empty neighbour
    if (k == MAX_FRAMES - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign hit_below  = 1'b0;
      assign tail_below = '0;
    end else begin : g_mid
      assign next_valid = cell_valid[k+1];
      assign hit_below  = cell_hit_below[k+1];
      assign tail_below = cell_tail[k+1];
    end

    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .ref_page_i   (page_i.page_number),
      .prev_page_i  (prev_page),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .hit_below_i  (hit_below),
      .tail_below_i (tail_below),
      .valid_o      (cell_valid[k]),
      .page_o       (cell_page[k]),
      .hit_o        (cell_hit[k]),
      .hit_below_o  (cell_hit_below[k]),
      .tail_o       (cell_tail[k])
    );
  end

  // --------------------------------------------------------------------------
  // Fault counter: advance on each miss, hold at the top
  // --------------------------------------------------------------------------
  logic [CntW-1:0] fcnt_q;
  logic [CntW-1:0] fcnt_d;

  always_comb begin
    fcnt_d = fcnt_q;
    if (!hit && (fcnt_q != lrupr_pkg::CountMax)) begin
      fcnt_d = fcnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else if (accept) begin
      fcnt_q <= fcnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result word: evict the oldest page only when no frame is free
  // --------------------------------------------------------------------------
  logic                 evict;
  logic [PAGE_BITS-1:0] ev_page;
  logic [ResW-1:0]      res_word;
  logic [ResW-1:0]      res_out;

  assign evict    = !hit && !fill;
  assign ev_page  = evict ? cell_tail[0] : '0;
  assign res_word = {!hit, evict, ev_page, fcnt_d};

  lrupr_out_buf #(
    .W (ResW)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (page_i.valid),
    .in_ready_o  (buf_ready),
    .in_data_i   (res_word),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_out)
  );

  assign res_o.fault         = res_out[ResW-1];
  assign res_o.evicted_valid = res_out[ResW-2];
  assign res_o.evicted_page  = res_out[CntW +: PAGE_BITS];
  assign res_o.fault_count   = res_out[CntW-1:0];

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `LRUPR_ASSERT(a_valid_prefix, clk_i, rst_ni, ((cell_valid >> 1) & ~cell_valid) == '0, "resident frames do not form a prefix")
  `LRUPR_ASSERT(a_unique_page, clk_i, rst_ni, $onehot0(cell_hit), "page resident in more than one frame")
  `LRUPR_ASSERT_NEXT(a_count_monotonic, clk_i, rst_ni, 1'b1, fcnt_q >= $past(fcnt_q), "fault count went down")
  `LRUPR_ASSERT_NEXT(a_hit_keeps_count, clk_i, rst_ni, accept && hit, cell_valid == $past(cell_valid), "hit changed the resident frame count")

endmodule

### tb/tb_lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Self-checking bench for the LRU page replacement unit. A local recency
// model predicts hit/fault, the evicted page and the fault count for every
// accepted page word; each result word is compared field by field. Directed
// tests cover the page extremes and the frame limit corner cases, then
// random traffic runs under several idle and stall patterns, then a long output hold-off.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;

  localparam int unsigned MaxFrames  = 8;
  localparam int unsigned PageW      = 16;
  localparam int unsigned PoolDepth  = 12;
  localparam int unsigned PhaseWords = 300;
  localparam int unsigned HoldCycles = 300;

  // Expected contents of one result word
  typedef struct packed {
    logic                             fault;
    logic                             evicted_valid;
    logic [PageW-1:0]                 evicted_page;
    logic [lrupr_pkg::CountW-1:0]     fault_count;
  } lru_outcome_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [lrupr_pkg::CfgW-1:0] cfg_wdata_i;

  lrupr_page_if #(.PAGE_BITS(PageW)) page_if ();
  lrupr_res_if  #(.PAGE_BITS(PageW)) res_if ();

  lru_page_replacement #(
    .MAX_FRAMES(MaxFrames),
    .PAGE_BITS (PageW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .page_i     (page_if),
    .res_o      (res_if)
  );

  // Local copy of the recency row, the frame register and the fault count
  logic [PageW-1:0]             resident [MaxFrames];
  int unsigned                  resident_n;
  logic [lrupr_pkg::CfgW-1:0]   frames_reg;
  logic [lrupr_pkg::CountW-1:0] fault_total;

  lru_outcome_t outcome_q [$];
  int unsigned  error_count;

  // Traffic shaping, percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Long receiver hold-off: bump hold_gen to request one
  int unsigned hold_gen;
  int unsigned hold_seen;
  int unsigned hold_left;

  logic [PageW-1:0] page_pool [PoolDepth];

  // Free-running clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Safety net: end the run if traffic ever hangs
  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Zero and oversized limits clamp to the legal frame range
  function automatic int unsigned frame_limit();
    if (frames_reg == '0) return 1;
    if (frames_reg > MaxFrames) return MaxFrames;
    return frames_reg;
  endfunction

  // Advance the recency model by one page reference and return its result
  function automatic lru_outcome_t lru_predict(logic [PageW-1:0] pg);
    lru_outcome_t res;
    int unsigned  pos;
    bit           hit;
    res = '0;
    pos = 0;
    hit = 1'b0;
    // Search only the valid prefix of the row
    for (int unsigned k = 0; k < resident_n; k++) begin
      if (!hit && resident[k] == pg) begin
        hit = 1'b1;
        pos = k;
      end
    end
    if (!hit) begin
      res.fault = 1'b1;
      if (fault_total != lrupr_pkg::CountMax) fault_total++;
      if (resident_n < frame_limit()) begin
        // Free frame left: grow the row
        pos = resident_n;
        resident_n++;
      end else begin
        // Row full (or over a lowered limit): drop the oldest page
        res.evicted_valid = 1'b1;
        res.evicted_page  = resident[resident_n-1];
        pos               = resident_n - 1;
      end
    end
    for (int unsigned k = pos; k > 0; k--) resident[k] = resident[k-1];
    resident[0]     = pg;
    res.fault_count = fault_total;
    return res;
  endfunction

  // Offer one page word, hold it until accepted, then record its prediction
  task automatic send_page(logic [PageW-1:0] pg);
    while ($urandom_range(99) < send_idle_pct) begin
      page_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    page_if.valid       <= 1'b1;
    page_if.page_number <= pg;
    do @(posedge clk_i); while (!page_if.ready);
    outcome_q.push_back(lru_predict(pg));
  endtask

  // Stop offering words and wait until every result word is back
  task automatic stop_and_drain();
    page_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the frame register; only call while the unit is idle
  task automatic write_frames(logic [lrupr_pkg::CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    frames_reg = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly reuse a small working set so hits and evictions both occur
  function automatic logic [PageW-1:0] pick_page();
    int unsigned span;
    span = frame_limit() + 3;
    if ($urandom_range(99) < 75) return page_pool[$urandom_range(span - 1)];
    return PageW'($urandom());
  endfunction

  task automatic refill_pool();
    foreach (page_pool[k]) page_pool[k] = PageW'($urandom());
  endtask

  // Compare one result word against the oldest expectation
  task automatic check_outcome();
    lru_outcome_t want;
    if (outcome_q.size() == 0) begin
      $error("result word arrived with nothing outstanding");
      error_count++;
    end else begin
      want = outcome_q.pop_front();
      if (res_if.fault !== want.fault) begin
        $error("fault: expected %0d, got %0d", want.fault, res_if.fault);
        error_count++;
      end
      if (res_if.evicted_valid !== want.evicted_valid) begin
        $error("evicted_valid: expected %0d, got %0d",
               want.evicted_valid, res_if.evicted_valid);
        error_count++;
      end
      if (res_if.evicted_page !== want.evicted_page) begin
        $error("evicted_page: expected 0x%04h, got 0x%04h",
               want.evicted_page, res_if.evicted_page);
        error_count++;
      end
      if (res_if.fault_count !== want.fault_count) begin
        $error("fault_count: expected %0d, got %0d",
               want.fault_count, res_if.fault_count);
        error_count++;
      end
    end
  endtask

  // Result sink: check each accepted word, then pick ready for the next edge.
  // A requested hold-off is counted down here, one cycle per edge.
  initial begin
    res_if.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) check_outcome();
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Reset limit of three frames: fill, hit, then evict the oldest page,
  // using both extreme page numbers.
  task automatic test_basic_replacement();
    send_idle_pct  = 0;
    recv_stall_pct = 21;
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h1234);
    send_page(16'hABCD);
    send_page(16'h1234);
    send_page(16'hFFFF);
  endtask

  // Frame limit corner cases: zero acting as one, oversized acting as the
  // maximum, a limit lowered below the resident count, a limit raised again.
  task automatic test_frame_limits();
    // Zero limit with three pages resident: residents still hit, misses
    // replace the oldest without shrinking the row.
    stop_and_drain();
    write_frames(4'd0);
    send_page(16'h1234);
    send_page(16'h5555);
    send_page(16'h5555);
    // Oversized limit: fill fresh frames up to the maximum, then evict
    stop_and_drain();
    write_frames(4'd15);
    send_page(16'h0101);
    send_page(16'h0202);
    send_page(16'h0404);
    send_page(16'h0808);
    send_page(16'h1010);
    send_page(16'h2020);
    // Lower the limit under a full row
    stop_and_drain();
    write_frames(4'd2);
    send_page(16'h2020);
    send_page(16'h0808);
    send_page(16'h7FFF);
    // Back to the full row
    stop_and_drain();
    write_frames(4'd8);
    send_page(16'h8000);
  endtask

  // Random traffic over one idle/stall pattern; drain halfway through to
  // change the frame limit while the unit is quiet.
  task automatic run_phase(int unsigned sidle, int unsigned rstall,
                           logic [lrupr_pkg::CfgW-1:0] frames_a);
    stop_and_drain();
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    write_frames(frames_a);
    refill_pool();
    for (int unsigned n = 0; n < PhaseWords; n++) begin
      if (n == PhaseWords / 2) begin
        stop_and_drain();
        write_frames(lrupr_pkg::CfgW'($urandom_range(2, 7)));
      end
      send_page(pick_page());
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0,  0,  4'd8);
    run_phase(73, 0,  4'd1);
    run_phase(0,  73, 4'd15);
    run_phase(21, 21, 4'd0);
  endtask

  // Hold the result side off for a long stretch while words keep coming,
  // so the output skid fills and the input stalls.
  task automatic test_output_stall();
    stop_and_drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_frames(4'd4);
    refill_pool();
    hold_gen++;
    for (int unsigned n = 0; n < 40; n++) send_page(pick_page());
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    page_if.valid       <= 1'b0;
    page_if.page_number <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_gen       = 0;
    error_count    = 0;
    resident_n     = 0;
    frames_reg     = lrupr_pkg::FramesReset;
    fault_total    = '0;
    foreach (resident[k]) resident[k] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_replacement();
    test_frame_limits();
    test_random_traffic();
    test_output_stall();

    // Let the last words through and leave the unit idle before the verdict
    stop_and_drain();
    repeat (4) @(posedge clk_i);

    if (error_count == 0 && outcome_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### lru_page_replacement.f
+incdir+src
src/lrupr_pkg.sv
src/lrupr_page_if.sv
src/lrupr_res_if.sv
src/lrupr_cell.sv
src/lrupr_out_buf.sv
src/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
